FILE: rtl/pde_pkg.sv
// ----------------------------------------------------------------------------
// pde_pkg
// shared types and constants for the pll divider encoder
// ----------------------------------------------------------------------------
`default_nettype none

package pde_pkg;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 16;
    localparam int ENC_W    = 17;
    localparam int LFSR_W   = 15;
    localparam int STEPS_W  = 16;
    localparam int LIMIT_W  = 17;

    // divider kind codes
    typedef enum logic [KIND_W-1:0] {
        KIND_POST     = 2'd0,
        KIND_PRE      = 2'd1,
        KIND_FEEDBACK = 2'd2,
        KIND_UNUSED   = 2'd3
    } kind_t;

    // upper limits of the raw value per kind
    localparam logic [LIMIT_W-1:0] POST_MAX     = 17'd32;
    localparam logic [LIMIT_W-1:0] PRE_MAX      = 17'd256;
    localparam logic [LIMIT_W-1:0] FEEDBACK_MAX = 17'd32768;

    // lfsr seeds
    localparam logic [LFSR_W-1:0] POST_SEED     = 15'h0010;
    localparam logic [LFSR_W-1:0] PRE_SEED      = 15'h0080;
    localparam logic [LFSR_W-1:0] FEEDBACK_SEED = 15'h4000;

    // fixed codes for raw values 0, 1 and 2
    localparam logic [ENC_W-1:0] POST_CODE0 = 17'h000FF;
    localparam logic [ENC_W-1:0] POST_CODE1 = 17'h00062;
    localparam logic [ENC_W-1:0] POST_CODE2 = 17'h00042;
    localparam logic [ENC_W-1:0] PRE_CODE0  = 17'h00FFF;
    localparam logic [ENC_W-1:0] PRE_CODE1  = 17'h00302;
    localparam logic [ENC_W-1:0] PRE_CODE2  = 17'h00202;
    localparam logic [ENC_W-1:0] FB_CODE0   = 17'h1FFFF;
    localparam logic [ENC_W-1:0] FB_CODE1   = 17'h18003;
    localparam logic [ENC_W-1:0] FB_CODE2   = 17'h10003;

    localparam logic [ENC_W-1:0] POST_MASK  = 17'h003FF;

    // command to the lfsr stepping unit
    typedef struct packed {
        logic                load;
        kind_t               kind;
        logic [LFSR_W-1:0]   seed;
        logic [STEPS_W-1:0]  steps;
    } lfsr_ctrl_t;

    // status back from the lfsr stepping unit
    typedef struct packed {
        logic                idle;
        logic [LFSR_W-1:0]   word;
    } lfsr_stat_t;

endpackage

`default_nettype wire

FILE: rtl/pde_if.sv
// ----------------------------------------------------------------------------
// pde channel interfaces
// valid/ready channels for divider requests and encoded words
// ----------------------------------------------------------------------------
`default_nettype none

interface pde_req_if import pde_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] divider_value;

    modport source (output valid, output kind, output divider_value, input ready);
    modport sink   (input valid, input kind, input divider_value, output ready);
endinterface

interface pde_rsp_if import pde_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [ENC_W-1:0]   encoded_value;

    modport source (output valid, output encoded_value, input ready);
    modport sink   (input valid, input encoded_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/pde_lfsr.sv
// ----------------------------------------------------------------------------
// pde_lfsr
// shared lfsr stepping unit: one shift per cycle until the count runs out
// ----------------------------------------------------------------------------
`default_nettype none

module pde_lfsr import pde_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire lfsr_ctrl_t ctrl,
    output lfsr_stat_t      stat
);

    logic [LFSR_W-1:0]  shift_reg,  shift_next;
    logic [STEPS_W-1:0] steps_reg,  steps_next;
    kind_t              kind_reg,   kind_next;
    logic [LFSR_W-1:0]  step_word;
    logic               fb;

    // one step of the polynomial selected by kind
    always_comb
    begin
        step_word = '0;
        fb        = 1'b0;
        unique case (kind_reg)
            KIND_POST:
            begin
                fb        = shift_reg[0] ^ shift_reg[2];
                step_word = {10'd0, fb, shift_reg[4:1]};
            end
            KIND_PRE:
            begin
                fb        = shift_reg[0] ^ shift_reg[2] ^ shift_reg[3] ^ shift_reg[4];
                step_word = {7'd0, fb, shift_reg[7:1]};
            end
            default:
            begin
                fb        = shift_reg[0] ^ shift_reg[1];
                step_word = {fb, shift_reg[14:1]};
            end
        endcase
    end

    always_comb
    begin
        shift_next = shift_reg;
        steps_next = steps_reg;
        kind_next  = kind_reg;
        if (ctrl.load)
        begin
            shift_next = ctrl.seed;
            steps_next = ctrl.steps;
            kind_next  = ctrl.kind;
        end
        else if (steps_reg != '0)
        begin
            shift_next = step_word;
            steps_next = steps_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            steps_reg <= '0;
            kind_reg  <= KIND_POST;
        end
        else
        begin
            shift_reg <= shift_next;
            steps_reg <= steps_next;
            kind_reg  <= kind_next;
        end
    end

    assign stat.idle = (steps_reg == '0) && !ctrl.load;
    assign stat.word = shift_reg;

endmodule

`default_nettype wire

FILE: rtl/pll_divider_lfsr_encoder.sv
// ----------------------------------------------------------------------------
// pll_divider_lfsr_encoder
// encodes a raw pll divider value into its lfsr-based register word
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                    | meaning
//  --------+-----+----------------------------+------------------------------
//  req     | in  | kind[1:0], divider_value   | divider kind and raw value
//  rsp     | out | encoded_value[16:0]        | encoded register word
//
//  a fixed code (raw 0, 1, 2) or an unused kind goes from ST_IDLE to
//  ST_DONE and then to the output register; a value above the limit loads
//  the seed and passes ST_RUN on the way; other values stay in ST_RUN
//  for max - value + 1 lfsr steps, up to 32766 for the feedback divider.
//  the single lfsr unit sets the rate: req is ready only while idle.
//  the result sits in an output register; a stalled rsp holds it and the
//  next request can already be taken and run. reset clears all control.
// ----------------------------------------------------------------------------
`default_nettype none

module pll_divider_lfsr_encoder import pde_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    pde_req_if.sink    req,
    pde_rsp_if.source  rsp
);

    // one-hot sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t             state_reg,   state_next;
    kind_t              kind_reg,    kind_next;
    logic [ENC_W-1:0]   result_reg,  result_next;
    logic               out_vld_reg, out_vld_next;
    logic [ENC_W-1:0]   out_reg,     out_next;

    lfsr_ctrl_t         lfsr_ctrl;
    lfsr_stat_t         lfsr_stat;

    kind_t              in_kind;
    logic [LIMIT_W-1:0] limit;
    logic [LIMIT_W-1:0] value_ext;
    logic [LIMIT_W-1:0] step_count;
    logic [LFSR_W-1:0]  seed;
    logic [ENC_W-1:0]   fixed_code;
    logic               is_fixed;
    logic               take;
    logic               slot_free;
    logic [ENC_W-1:0]   lfsr_result;

    pde_lfsr u_lfsr
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lfsr_ctrl),
        .stat  (lfsr_stat)
    );

    assign in_kind   = kind_t'(req.kind);
    assign value_ext = {1'b0, req.divider_value};
    assign take      = req.valid && req.ready;
    assign slot_free = !out_vld_reg || rsp.ready;

    // per-kind seed, limit and fixed codes
    always_comb
    begin
        limit      = FEEDBACK_MAX;
        seed       = FEEDBACK_SEED;
        fixed_code = '0;
        is_fixed   = 1'b1;
        unique case (in_kind)
            KIND_POST:
            begin
                limit    = POST_MAX;
                seed     = POST_SEED;
                is_fixed = (req.divider_value < 16'd3);
                unique case (req.divider_value[1:0])
                    2'd0:    fixed_code = POST_CODE0;
                    2'd1:    fixed_code = POST_CODE1;
                    default: fixed_code = POST_CODE2;
                endcase
            end
            KIND_PRE:
            begin
                limit    = PRE_MAX;
                seed     = PRE_SEED;
                is_fixed = (req.divider_value < 16'd3);
                unique case (req.divider_value[1:0])
                    2'd0:    fixed_code = PRE_CODE0;
                    2'd1:    fixed_code = PRE_CODE1;
                    default: fixed_code = PRE_CODE2;
                endcase
            end
            KIND_FEEDBACK:
            begin
                is_fixed = (req.divider_value < 16'd3);
                unique case (req.divider_value[1:0])
                    2'd0:    fixed_code = FB_CODE0;
                    2'd1:    fixed_code = FB_CODE1;
                    default: fixed_code = FB_CODE2;
                endcase
            end
            default:
            begin
                // unused kind reports zero and leaves the lfsr alone
                is_fixed   = 1'b1;
                fixed_code = '0;
            end
        endcase
    end

    // steps to run; a value above the limit runs none and returns the seed
    assign step_count = (value_ext <= limit) ? (limit - value_ext + 1'b1) : '0;

    // post word is kept to 10 bits; pre and feedback words fit as they are
    assign lfsr_result = (kind_reg == KIND_POST)
                         ? ({2'd0, lfsr_stat.word} & POST_MASK)
                         : {2'd0, lfsr_stat.word};

    always_comb
    begin
        lfsr_ctrl.load  = take && !is_fixed;
        lfsr_ctrl.kind  = in_kind;
        lfsr_ctrl.seed  = seed;
        lfsr_ctrl.steps = step_count[STEPS_W-1:0];
    end

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        result_next  = result_reg;
        out_vld_next = out_vld_reg;
        out_next     = out_reg;

        if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    kind_next = in_kind;
                    if (is_fixed)
                    begin
                        result_next = fixed_code;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (lfsr_stat.idle)
                begin
                    result_next = lfsr_result;
                    state_next  = ST_DONE;
                end
            end
            default:
            begin
                // hand the word to the output register once it is free
                if (slot_free)
                begin
                    out_next     = result_reg;
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            kind_reg    <= KIND_POST;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        out_reg    <= out_next;
    end

    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = out_vld_reg;
    assign rsp.encoded_value = out_reg;

endmodule

`default_nettype wire

FILE: tb/pde_encode_checker.sv
// ----------------------------------------------------------------------------
// pde_encode_checker
// watches the request and result channels of the pll divider encoder,
// predicts each encoded word and compares it with what comes out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pde_encode_checker import pde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pde_req_if          req,
    pde_rsp_if          rsp,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned checked
);

    logic [ENC_W-1:0]  expected_words[$];
    int unsigned       fail_n;
    int unsigned       checked_n;
    int unsigned       pending_n;

    assign fail_count = fail_n;
    assign pending    = pending_n;
    assign checked    = checked_n;

    function automatic logic [LFSR_W-1:0] lfsr_advance(kind_t k, logic [LFSR_W-1:0] x);
        case (k)
            KIND_POST: return {10'b0, x[0] ^ x[2], x[4:1]};
            KIND_PRE:  return {7'b0, x[0] ^ x[2] ^ x[3] ^ x[4], x[7:1]};
            default:   return {x[0] ^ x[1], x[14:1]};
        endcase
    endfunction

    // encoded word for one request
    function automatic logic [ENC_W-1:0] encode_divider(kind_t k, logic [VALUE_W-1:0] v);
        logic [LFSR_W-1:0] word;
        int unsigned       limit;
        int unsigned       steps;
        case (k)
            KIND_POST:
            begin
                word  = POST_SEED;
                limit = POST_MAX;
            end
            KIND_PRE:
            begin
                word  = PRE_SEED;
                limit = PRE_MAX;
            end
            KIND_FEEDBACK:
            begin
                word  = FEEDBACK_SEED;
                limit = FEEDBACK_MAX;
            end
            default: return '0;
        endcase
        if (v == 0)
            return (k == KIND_POST) ? POST_CODE0 : (k == KIND_PRE) ? PRE_CODE0 : FB_CODE0;
        if (v == 1)
            return (k == KIND_POST) ? POST_CODE1 : (k == KIND_PRE) ? PRE_CODE1 : FB_CODE1;
        if (v == 2)
            return (k == KIND_POST) ? POST_CODE2 : (k == KIND_PRE) ? PRE_CODE2 : FB_CODE2;
        // above the limit the seed comes back untouched
        steps = (v <= limit) ? limit - v + 1 : 0;
        repeat (steps) word = lfsr_advance(k, word);
        if (k == KIND_POST)
            return {2'b0, word} & POST_MASK;
        return {2'b0, word};
    endfunction

    task automatic report_failure(string what, logic [ENC_W-1:0] want, logic [ENC_W-1:0] got);
        fail_n++;
        if (fail_n <= 10)
            $display("tb: %s at %0t: expected 0x%05h, got 0x%05h", what, $realtime, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [ENC_W-1:0] want;
        if (!rst_n)
        begin
            expected_words.delete();
            fail_n    = 0;
            checked_n = 0;
            pending_n = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_words.push_back(encode_divider(kind_t'(req.kind), req.divider_value));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_words.size() == 0)
                    report_failure("unexpected result", '0, rsp.encoded_value);
                else
                begin
                    want = expected_words.pop_front();
                    checked_n++;
                    if (rsp.encoded_value !== want)
                        report_failure("encoded_value mismatch", want, rsp.encoded_value);
                end
            end
            pending_n = expected_words.size();
        end
    end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives divider requests into the pll divider encoder in random bursts,
// stalls the result side on a shifting pattern and reports the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import pde_pkg::*; ;

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;

    // per-kind request tally for the summary
    int unsigned kind_count[4];
    // transfers left before the sender takes a break
    int          burst_left;

    // receiver stall pattern state
    int          stall_mode = 0;
    int          mode_left  = 0;
    logic [7:0]  rsp_phase  = '0;

    pde_req_if req_ch();
    pde_rsp_if rsp_ch();

    pll_divider_lfsr_encoder dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // prediction and comparison live beside the block
    pde_encode_checker enc_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop; even if every request ran the longest lfsr sequence the
    // run would stay well under a quarter of this
    initial
    begin
        #40_000_000;
        $display("tb: timeout with %0d results outstanding", pending);
        $display("tb: done, errors");
        $finish;
    end

    // result side: every so often pick a new stall pattern
    //   mode 0 always ready, mode 1 coin flip, mode 2 mostly stalled,
    //   mode 3 ready while the low three bits of rsp_phase are below 3
    always @(posedge clk)
    begin
        rsp_phase <= rsp_phase + 8'd1;
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(16, 200);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= (rsp_phase[2:0] < 3'd3);
        endcase
    end

    // one request transfer; valid stays high inside a burst and drops for a
    // random gap once the burst runs out
    task automatic send_request(kind_t k, logic [VALUE_W-1:0] v);
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= k;
        req_ch.divider_value <= v;
        kind_count[int'(k)]++;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    // values lean toward short lfsr runs; a long feedback run is rare since
    // it costs up to 32766 lfsr steps
    function automatic logic [VALUE_W-1:0] pick_value(kind_t k);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        case (k)
            KIND_POST:
                if (sel < 15)      return VALUE_W'($urandom_range(0, 2));
                else if (sel < 75) return VALUE_W'($urandom_range(3, 32));
                else               return VALUE_W'($urandom_range(33, 65535));
            KIND_PRE:
                if (sel < 15)      return VALUE_W'($urandom_range(0, 2));
                else if (sel < 75) return VALUE_W'($urandom_range(3, 256));
                else               return VALUE_W'($urandom_range(257, 65535));
            KIND_FEEDBACK:
                if (sel < 15)      return VALUE_W'($urandom_range(0, 2));
                else if (sel < 70) return VALUE_W'($urandom_range(32468, 32768));
                else if (sel < 97) return VALUE_W'($urandom_range(32769, 65535));
                else               return VALUE_W'($urandom_range(3, 32767));
            default:
                return VALUE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic kind_t pick_kind();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)      return KIND_POST;
        else if (sel < 6) return KIND_PRE;
        else if (sel < 9) return KIND_FEEDBACK;
        return KIND_UNUSED;
    endfunction

    initial
    begin
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.kind          = '0;
        req_ch.divider_value = '0;
        rsp_ch.ready         = 1'b0;
        burst_left           = 0;
        foreach (kind_count[i]) kind_count[i] = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fixed codes, first lfsr value, at the limit, just above
        // it, and the top of the field for post and feedback
        send_request(KIND_POST, 16'd0);
        send_request(KIND_POST, 16'd1);
        send_request(KIND_POST, 16'd2);
        send_request(KIND_POST, 16'd3);
        send_request(KIND_POST, 16'd31);
        send_request(KIND_POST, 16'd32);
        send_request(KIND_POST, 16'd33);
        send_request(KIND_POST, 16'hFFFF);
        send_request(KIND_PRE, 16'd0);
        send_request(KIND_PRE, 16'd1);
        send_request(KIND_PRE, 16'd2);
        send_request(KIND_PRE, 16'd3);
        send_request(KIND_PRE, 16'd255);
        send_request(KIND_PRE, 16'd256);
        send_request(KIND_PRE, 16'd257);
        send_request(KIND_FEEDBACK, 16'd0);
        send_request(KIND_FEEDBACK, 16'd1);
        send_request(KIND_FEEDBACK, 16'd2);
        // longest lfsr run of the block
        send_request(KIND_FEEDBACK, 16'd3);
        send_request(KIND_FEEDBACK, 16'd32767);
        send_request(KIND_FEEDBACK, 16'd32768);
        send_request(KIND_FEEDBACK, 16'd32769);
        send_request(KIND_FEEDBACK, 16'hFFFF);
        // unused kind gives zero
        send_request(KIND_UNUSED, 16'h1234);
        send_request(KIND_UNUSED, 16'hFFFF);

        // random part
        repeat (75)
        begin
            kind_t k;
            k = pick_kind();
            send_request(k, pick_value(k));
        end
        req_ch.valid <= 1'b0;

        // let the checker see the last transfer, then drain
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("tb: %0d requests (post %0d, pre %0d, feedback %0d, unused %0d)",
                 kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3],
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
        $display("tb: %0d encoded words checked under bursty requests and result stalls",
                 checked);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
